// ===== rtl/fmeg_pkg.sv =====
`timescale 1ns / 1ps

package fmeg_pkg;

    // Envelope phases, one-hot
    typedef enum logic [3:0] {
        PH_ATTACK  = 4'b0001,
        PH_DECAY   = 4'b0010,
        PH_SUSTAIN = 4'b0100,
        PH_RELEASE = 4'b1000
    } t_env_phase;

    // Configuration register indexes
    localparam logic [2:0] CFG_TOTAL_LEVEL   = 3'd0;
    localparam logic [2:0] CFG_KSL_MODE      = 3'd1;
    localparam logic [2:0] CFG_ATK_CODE      = 3'd2;
    localparam logic [2:0] CFG_DCY_CODE      = 3'd3;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd4;
    localparam logic [2:0] CFG_REL_CODE      = 3'd5;
    localparam logic [2:0] CFG_KEY_DELAY     = 3'd6;
    localparam logic [2:0] CFG_MODE_FLAGS    = 3'd7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 6;

    // Mode flag bit positions
    localparam int MF_TREM_ON   = 0;
    localparam int MF_TREM_DEEP = 1;
    localparam int MF_SUS_HOLD  = 2;
    localparam int MF_KSR       = 3;

    localparam logic [8:0] POS_OFF_MASK = 9'h1f8;
    localparam logic [8:0] POS_SILENT   = 9'h1ff;
    localparam logic [8:0] DELAY_START  = 9'h100;
    localparam logic [3:0] RATE_MAX     = 4'hf;

    typedef struct packed {
        logic [5:0] total_level;
        logic [1:0] ksl_mode;
        logic [3:0] atk_code;
        logic [3:0] dcy_code;
        logic [3:0] sustain_level;
        logic [3:0] rel_code;
        logic [2:0] key_delay;
        logic [3:0] mode_flags;
    } t_cfg;

    // Effective rate and step size between rate unit and the core
    typedef struct packed {
        logic [3:0] rate_hi;
        logic [1:0] step;
    } t_rate_info;

    function automatic logic [1:0] phase_code(input t_env_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_ATTACK:  code = 2'd0;
            PH_DECAY:   code = 2'd1;
            PH_SUSTAIN: code = 2'd2;
            PH_RELEASE: code = 2'd3;
            default:    code = 2'd3;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/fmeg_cfg_regs.sv =====
`timescale 1ns / 1ps

module fmeg_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fmeg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [fmeg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output fmeg_pkg::t_cfg                  o_cfg
);
    import fmeg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_TOTAL_LEVEL:   r_cfg.total_level   <= i_cfg_wdata;
                CFG_KSL_MODE:      r_cfg.ksl_mode      <= i_cfg_wdata[1:0];
                CFG_ATK_CODE:      r_cfg.atk_code      <= i_cfg_wdata[3:0];
                CFG_DCY_CODE:      r_cfg.dcy_code      <= i_cfg_wdata[3:0];
                CFG_SUSTAIN_LEVEL: r_cfg.sustain_level <= i_cfg_wdata[3:0];
                CFG_REL_CODE:      r_cfg.rel_code      <= i_cfg_wdata[3:0];
                CFG_KEY_DELAY:     r_cfg.key_delay     <= i_cfg_wdata[2:0];
                CFG_MODE_FLAGS:    r_cfg.mode_flags    <= i_cfg_wdata[3:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/fmeg_atten.sv =====
`timescale 1ns / 1ps

module fmeg_atten (
    input  logic [8:0]     i_old_pos,
    input  fmeg_pkg::t_cfg i_cfg,
    input  logic [7:0]     i_level_offset,
    input  logic [6:0]     i_tremolo_value,
    output logic [9:0]     o_attenuation
);
    import fmeg_pkg::*;

    logic [7:0]  ksl_term;
    logic [4:0]  trem_term;
    logic [10:0] sum;

    always_comb begin
        unique case (i_cfg.ksl_mode)
            2'd0:    ksl_term = 8'd0;
            2'd1:    ksl_term = {1'b0, i_level_offset[7:1]};
            2'd2:    ksl_term = {2'b00, i_level_offset[7:2]};
            2'd3:    ksl_term = i_level_offset;
            default: ksl_term = 8'd0;
        endcase

        if (!i_cfg.mode_flags[MF_TREM_ON]) begin
            trem_term = 5'd0;
        end else if (i_cfg.mode_flags[MF_TREM_DEEP]) begin
            trem_term = i_tremolo_value[6:2];
        end else begin
            trem_term = {2'b00, i_tremolo_value[6:4]};
        end

        sum = {2'b00, i_old_pos} + {3'b000, i_cfg.total_level, 2'b00}
            + {3'b000, ksl_term} + {6'b000000, trem_term};

        // saturate: anything past the top is silent anyway
        o_attenuation = sum[10] ? 10'h3ff : sum[9:0];
    end

endmodule

// ===== rtl/fmeg_rate.sv =====
`timescale 1ns / 1ps

module fmeg_rate (
    input  logic [3:0]           i_sel_rate,
    input  logic [3:0]           i_key_scale,
    input  logic                 i_ksr,
    input  logic [1:0]           i_tick_lo,
    input  logic                 i_half_tick,
    input  logic [3:0]           i_dither_clocks,
    output fmeg_pkg::t_rate_info o_rate
);
    import fmeg_pkg::*;

    localparam logic [4:0] ES_FULL = 5'd12;
    localparam logic [4:0] ES_HI   = 5'd13;
    localparam logic [4:0] ES_LO   = 5'd14;
    localparam logic [3:0] RATE_FAST = 4'd12;

    logic [3:0] ks;
    logic [6:0] rate;
    logic [3:0] rate_hi;
    logic [1:0] rate_lo;
    logic [4:0] es;
    logic [3:0] fine_mask;
    logic [2:0] fast_sum;
    logic [1:0] step;

    always_comb begin
        ks      = i_ksr ? i_key_scale : {2'b00, i_key_scale[3:2]};
        rate    = {3'b000, ks} + {1'b0, i_sel_rate, 2'b00};
        rate_lo = rate[1:0];
        rate_hi = rate[6] ? RATE_MAX : rate[5:2];

        // fine increment pattern per low rate bits, indexed by timer
        unique case (rate_lo)
            2'd0:    fine_mask = 4'b0000;
            2'd1:    fine_mask = 4'b0001;
            2'd2:    fine_mask = 4'b0101;
            2'd3:    fine_mask = 4'b0111;
            default: fine_mask = 4'b0000;
        endcase

        es       = {1'b0, rate_hi} + {1'b0, i_dither_clocks};
        fast_sum = {1'b0, rate_hi[1:0]} + {2'b00, fine_mask[i_tick_lo]};

        step = 2'd0;
        if (i_sel_rate != 4'd0) begin
            if (rate_hi < RATE_FAST) begin
                if (i_half_tick) begin
                    if (es == ES_FULL) begin
                        step = 2'd1;
                    end else if (es == ES_HI) begin
                        step = {1'b0, rate_lo[1]};
                    end else if (es == ES_LO) begin
                        step = {1'b0, rate_lo[0]};
                    end
                end
            end else if (fast_sum[2]) begin
                step = 2'd3;
            end else if (fast_sum[1:0] == 2'd0) begin
                step = {1'b0, i_half_tick};
            end else begin
                step = fast_sum[1:0];
            end
        end

        o_rate.rate_hi = rate_hi;
        o_rate.step    = step;
    end

endmodule

// ===== rtl/fm_operator_envelope_generator_unit.sv =====
`timescale 1ns / 1ps

// Envelope generator for one FM operator. Each input request carries one
// sample tick (key state, key scale, level offset, tremolo and timer bits);
// each one yields exactly one result: the total attenuation from the position
// held before the tick, the attack-restart pulse, and the new phase and
// position. The whole update is one pass of shifts, adds and compares from the
// held envelope state into the output register, so a request is taken every
// clock cycle unless stalled, and its result shows on the master side in the next
// cycle. The slave side stalls only while the output register holds a result that
// the master side has not taken. Configuration registers are written through the
// plain write port and must only change while no request is in flight.
module fm_operator_envelope_generator_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [fmeg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [fmeg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // key_on[0], key_scale[4:1], level_offset[12:5], tremolo_value[19:13],
    // global_tick[29:20], half_tick[30], dither_clocks[34:31], zero[39:35]
    input  logic [39:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // attenuation[9:0], phase_restart[10], env_phase[12:11],
    // env_position[21:13], zero[23:22]
    output logic [23:0]                     m_axis_tdata
);
    import fmeg_pkg::*;

    t_cfg       cfg;
    t_rate_info rate_info;

    logic       key_on;
    logic [3:0] key_scale;
    logic [7:0] level_offset;
    logic [6:0] tremolo_value;
    logic [9:0] global_tick;
    logic       half_tick;
    logic [3:0] dither_clocks;

    t_env_phase r_phase, n_phase;
    logic [8:0] r_position, n_position;
    logic       r_delay_running, n_delay_running;
    logic [8:0] r_delay_count, n_delay_count;
    logic       r_out_valid;
    logic [23:0] r_out_data;

    logic       accept;
    logic [9:0] attenuation;
    logic [3:0] sel_rate;
    logic       restart;
    logic [8:0] dc_eff;
    logic       tick_hit;
    logic       off;
    logic [8:0] rout;
    logic [8:0] inc;
    logic [8:0] exp_shifted;
    logic       step_ok;

    assign key_on        = s_axis_tdata[0];
    assign key_scale     = s_axis_tdata[4:1];
    assign level_offset  = s_axis_tdata[12:5];
    assign tremolo_value = s_axis_tdata[19:13];
    assign global_tick   = s_axis_tdata[29:20];
    assign half_tick     = s_axis_tdata[30];
    assign dither_clocks = s_axis_tdata[34:31];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    fmeg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    fmeg_atten u_atten (
        .i_old_pos       (r_position),
        .i_cfg           (cfg),
        .i_level_offset  (level_offset),
        .i_tremolo_value (tremolo_value),
        .o_attenuation   (attenuation)
    );

    fmeg_rate u_rate (
        .i_sel_rate      (sel_rate),
        .i_key_scale     (key_scale),
        .i_ksr           (cfg.mode_flags[MF_KSR]),
        .i_tick_lo       (global_tick[1:0]),
        .i_half_tick     (half_tick),
        .i_dither_clocks (dither_clocks),
        .o_rate          (rate_info)
    );

    // Rate selection and key-on delay
    always_comb begin
        n_delay_running = r_delay_running;
        n_delay_count   = r_delay_count;
        restart         = 1'b0;
        sel_rate        = 4'd0;
        tick_hit        = global_tick[cfg.key_delay];

        if (r_delay_running) begin
            dc_eff = r_delay_count;
        end else begin
            dc_eff = (cfg.key_delay != 3'd0) ? DELAY_START : 9'd0;
        end

        if (key_on && (r_phase == PH_RELEASE)) begin
            n_delay_count = dc_eff;
            if (dc_eff == 9'd0) begin
                n_delay_running = 1'b0;
                restart         = 1'b1;
                sel_rate        = cfg.atk_code;
            end else begin
                n_delay_running = 1'b1;
                if (tick_hit) begin
                    n_delay_count = dc_eff - 9'd1;
                end
                sel_rate = cfg.rel_code;
            end
        end else begin
            unique case (r_phase)
                PH_ATTACK:  sel_rate = cfg.atk_code;
                PH_DECAY:   sel_rate = cfg.dcy_code;
                PH_SUSTAIN: sel_rate = cfg.mode_flags[MF_SUS_HOLD] ? 4'd0 : cfg.rel_code;
                PH_RELEASE: sel_rate = cfg.rel_code;
                default:    sel_rate = cfg.rel_code;
            endcase
        end

        if (!key_on) begin
            n_delay_running = 1'b0;
        end
    end

    // Position and phase update
    always_comb begin
        off         = (r_position & POS_OFF_MASK) == POS_OFF_MASK;
        step_ok     = rate_info.step != 2'd0;
        exp_shifted = r_position >> (3'd4 - {1'b0, rate_info.step});
        inc         = 9'd0;
        n_phase     = r_phase;

        rout = r_position;
        if (restart && (rate_info.rate_hi == RATE_MAX)) begin
            rout = 9'd0;
        end
        // envelope off: park at silence
        if ((r_phase != PH_ATTACK) && !restart && off) begin
            rout = POS_SILENT;
        end

        unique case (r_phase)
            PH_ATTACK: begin
                if (r_position == 9'd0) begin
                    n_phase = PH_DECAY;
                end else if (key_on && step_ok && (rate_info.rate_hi != RATE_MAX)) begin
                    inc = ~exp_shifted;
                end
            end
            PH_DECAY: begin
                if (r_position[8:4] == {1'b0, cfg.sustain_level}) begin
                    n_phase = PH_SUSTAIN;
                end else if (!off && !restart && step_ok) begin
                    inc = 9'd1 << (rate_info.step - 2'd1);
                end
            end
            default: begin
                if (!off && !restart && step_ok) begin
                    inc = 9'd1 << (rate_info.step - 2'd1);
                end
            end
        endcase

        n_position = rout + inc;
        if (restart) begin
            n_phase = PH_ATTACK;
        end
        if (!key_on) begin
            n_phase = PH_RELEASE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_RELEASE;
            r_position      <= POS_SILENT;
            r_delay_running <= 1'b0;
            r_delay_count   <= 9'd0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_phase         <= n_phase;
                r_position      <= n_position;
                r_delay_running <= n_delay_running;
                r_delay_count   <= n_delay_count;
                r_out_valid     <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, n_position, phase_code(n_phase), restart, attenuation};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
